### design/bbc_pkg.sv
// Shared constants, widths and the CORDIC arctangent table for the bearing unit.
`default_nettype none

package bbc_pkg;

    // Angles are degrees * 2^24 inside the datapath.
    localparam int ZW      = 34;   // CORDIC angle accumulator width (signed)
    localparam int COS_W   = 33;   // cosine CORDIC x/y width (signed, Q30)
    localparam int ATAN_W  = 58;   // vectoring CORDIC x/y width (signed)

    localparam logic [30:0] DEG90      = 31'd1509949440;
    localparam logic [32:0] DEG180     = 33'd3019898880;
    localparam logic [32:0] DEG360     = 33'd6039797760;
    localparam logic [29:0] LAT90      = 30'd377487360;  // 90 deg at input scale
    localparam logic [29:0] LAT180     = 30'd754974720;  // 180 deg at input scale
    localparam logic [32:0] INV_GAIN   = 33'd652032874;  // 1/K in Q30
    localparam logic [30:0] ONE_Q30    = 31'd1073741824;
    localparam logic [25:0] FULL_TURN  = 26'd23592960;   // 360 deg at output scale

    // atan(2^-i) in degrees * 2^24
    function automatic logic [31:0] atan_step(input int i);
        logic [63:0] t;
        t = 64'd0;
        case (i)
            0: return 32'd754974720;
            1: return 32'd445687602;
            2: return 32'd235489088;
            3: return 32'd119537938;
            4: return 32'd60000934;
            5: return 32'd30029717;
            6: return 32'd15018523;
            7: return 32'd7509720;
            8: return 32'd3754917;
            9: return 32'd1877466;
            10: return 32'd938734;
            default:
            begin
                t = (64'd961263669 + (64'd1 << (i - 1))) >> i;
                return t[31:0];
            end
        endcase
    endfunction

endpackage

`default_nettype wire

### design/bbc_cordic.sv
// Unrolled CORDIC pipeline, one register stage per step, rotation or vectoring mode.
`default_nettype none

module bbc_cordic #(
    parameter int N      = 20,
    parameter int W      = 33,
    parameter int SW     = 4,
    parameter bit VECTOR = 1'b0
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire logic signed [W-1:0]         in_x,
    input  wire logic signed [W-1:0]         in_y,
    input  wire logic signed [bbc_pkg::ZW-1:0] in_z,
    input  wire logic [SW-1:0]               in_side,
    output logic                             out_valid,
    output logic signed [W-1:0]              out_x,
    output logic signed [bbc_pkg::ZW-1:0]    out_z,
    output logic [SW-1:0]                    out_side
);
    import bbc_pkg::*;

    logic                valid_reg [N];
    logic signed [W-1:0] x_reg     [N];
    logic signed [W-1:0] y_reg     [N];
    logic signed [ZW-1:0] z_reg    [N];
    logic [SW-1:0]       side_reg  [N];

    for (genvar i = 0; i < N; i++)
    begin : g_step
        logic                 vi;
        logic signed [W-1:0]  xi;
        logic signed [W-1:0]  yi;
        logic signed [ZW-1:0] zi;
        logic [SW-1:0]        si;
        logic signed [W-1:0]  dx;
        logic signed [W-1:0]  dy;
        logic signed [ZW-1:0] at;
        logic                 pos;

        if (i == 0)
        begin : g_first
            assign vi = in_valid;
            assign xi = in_x;
            assign yi = in_y;
            assign zi = in_z;
            assign si = in_side;
        end
        else
        begin : g_next
            assign vi = valid_reg[i-1];
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign zi = z_reg[i-1];
            assign si = side_reg[i-1];
        end

        assign dx  = yi >>> i;
        assign dy  = xi >>> i;
        assign at  = $signed({{(ZW-32){1'b0}}, atan_step(i)});
        // rotation follows the residual angle, vectoring drives y toward zero
        assign pos = VECTOR ? !(yi > 0) : (zi >= 0);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (en)
                valid_reg[i] <= vi;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i]    <= pos ? xi - dx : xi + dx;
                y_reg[i]    <= pos ? yi + dy : yi - dy;
                z_reg[i]    <= pos ? zi - at : zi + at;
                side_reg[i] <= si;
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign out_x     = x_reg[N-1];
    assign out_z     = z_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

`default_nettype wire

### design/bearing_between_coordinates_unit.sv
// Top level: flat-earth initial bearing between two fixed-point coordinates.
`default_nettype none

// Takes a start and a target point (degrees * 2^22) and returns the bearing
// clockwise from north (degrees * 2^16, 360 wraps to 0); coincident points give
// bearing 0 with m_tuser set. A new transaction is accepted every cycle while
// s_tready is high; the path runs through an input stage, the cosine CORDIC
// pipeline, a 31x31 multiply stage, the arctangent CORDIC pipeline, a clamp
// stage and the output register. A one-entry skid behind the output register
// lets the pipeline keep moving while a result waits; s_tready drops only when
// that skid entry is full.
module bearing_between_coordinates_unit #(
    parameter int CORDIC_STEPS = 20
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // from_lon[30:0], from_lat[60:31], to_lon[91:61], to_lat[121:92]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [31:0]       m_tdata,   // bearing[24:0]
    output logic              m_tuser    // same_point
);
    import bbc_pkg::*;

    typedef struct packed {
        logic dlo_neg;
        logic dlo_zero;
        logic dla_neg;
        logic dla_zero;
    } sign_t;

    logic en;

    // ---------------- input stage
    logic signed [30:0] from_lon;
    logic signed [29:0] from_lat;
    logic signed [30:0] to_lon;
    logic signed [29:0] to_lat;
    logic signed [31:0] dlo;
    logic signed [30:0] dla;
    logic [31:0]        dlo_mag;
    logic [30:0]        dla_mag;
    logic [29:0]        lat_mag;

    assign from_lon = s_tdata[30:0];
    assign from_lat = s_tdata[60:31];
    assign to_lon   = s_tdata[91:61];
    assign to_lat   = s_tdata[121:92];
    assign dlo      = 32'(to_lon) - 32'(from_lon);
    assign dla      = 31'(to_lat) - 31'(from_lat);
    assign dlo_mag  = dlo[31] ? -dlo : dlo;
    assign dla_mag  = dla[30] ? -dla : dla;
    assign lat_mag  = from_lat[29] ? -from_lat : from_lat;

    logic        s1_valid_reg;
    logic [30:0] s1_ulo_reg;
    logic [29:0] s1_ula_reg;
    logic        s1_dlo_neg_reg;
    logic        s1_dla_neg_reg;
    logic [29:0] s1_lat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ulo_reg     <= dlo_mag[30:0];
            s1_ula_reg     <= dla_mag[29:0];
            s1_dlo_neg_reg <= dlo[31];
            s1_dla_neg_reg <= dla[30];
            s1_lat_reg     <= lat_mag;
        end
    end

    // ---------------- cosine of start latitude
    logic [29:0]             lat_red;
    logic signed [ZW-1:0]    cos_z0;
    logic                    cos_valid;
    logic signed [COS_W-1:0] cos_x;
    logic signed [ZW-1:0]    cos_z_unused;
    logic [62:0]             cos_side;

    // latitudes past the pole fold back to 180 - |lat|
    assign lat_red = (s1_lat_reg > LAT90) ? LAT180 - s1_lat_reg : s1_lat_reg;
    assign cos_z0  = $signed({{(ZW-32){1'b0}}, lat_red, 2'b00});

    bbc_cordic #(
        .N      (CORDIC_STEPS),
        .W      (COS_W),
        .SW     (63),
        .VECTOR (1'b0)
    ) u_cos (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s1_valid_reg),
        .in_x      ($signed(INV_GAIN)),
        .in_y      ('0),
        .in_z      (cos_z0),
        .in_side   ({s1_ulo_reg, s1_ula_reg, s1_dlo_neg_reg, s1_dla_neg_reg}),
        .out_valid (cos_valid),
        .out_x     (cos_x),
        .out_z     (cos_z_unused),
        .out_side  (cos_side)
    );

    // ---------------- multiply stage
    logic [30:0] cos_q30;
    logic [30:0] m_ulo;
    logic [29:0] m_ula;
    logic [61:0] east_prod;

    assign m_ulo = cos_side[62:32];
    assign m_ula = cos_side[31:2];

    always_comb
    begin
        if (cos_x < 0)
            cos_q30 = '0;
        else if (cos_x > $signed({2'b00, ONE_Q30}))
            cos_q30 = ONE_Q30;
        else
            cos_q30 = cos_x[30:0];
    end

    assign east_prod = 62'(m_ulo) * 62'(cos_q30);

    logic        mul_valid_reg;
    logic [53:0] mul_east_reg;
    logic [29:0] mul_ula_reg;
    sign_t       mul_sign_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_valid_reg <= 1'b0;
        else if (en)
            mul_valid_reg <= cos_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_east_reg          <= east_prod[61:8];
            mul_ula_reg           <= m_ula;
            mul_sign_reg.dlo_neg  <= cos_side[1];
            mul_sign_reg.dlo_zero <= (m_ulo == '0);
            mul_sign_reg.dla_neg  <= cos_side[0];
            mul_sign_reg.dla_zero <= (m_ula == '0);
        end
    end

    // ---------------- arctangent of east / north
    logic                     atan_valid;
    logic signed [ATAN_W-1:0] atan_x_unused;
    logic signed [ZW-1:0]     atan_z;
    logic [3:0]               atan_side;

    bbc_cordic #(
        .N      (CORDIC_STEPS),
        .W      (ATAN_W),
        .SW     (4),
        .VECTOR (1'b1)
    ) u_atan (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (mul_valid_reg),
        .in_x      ($signed({6'b0, mul_ula_reg, 22'b0})),
        .in_y      ($signed({4'b0, mul_east_reg})),
        .in_z      ('0),
        .in_side   (mul_sign_reg),
        .out_valid (atan_valid),
        .out_x     (atan_x_unused),
        .out_z     (atan_z),
        .out_side  (atan_side)
    );

    // ---------------- clamp stage
    sign_t       f_sign;
    logic [30:0] a_next;

    assign f_sign = atan_side;

    always_comb
    begin
        if (f_sign.dla_zero || atan_z > $signed({3'b000, DEG90}))
            a_next = DEG90;
        else if (atan_z < 0)
            a_next = '0;
        else
            a_next = atan_z[30:0];
    end

    logic        f1_valid_reg;
    logic [30:0] f1_a_reg;
    sign_t       f1_sign_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f1_valid_reg <= 1'b0;
        else if (en)
            f1_valid_reg <= atan_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_a_reg    <= a_next;
            f1_sign_reg <= f_sign;
        end
    end

    // ---------------- quadrant, rounding, wrap
    logic        same;
    logic        lo_pos;
    logic        lo_neg;
    logic        la_pos;
    logic        la_neg;
    logic [32:0] b;
    logic [33:0] rnd;
    logic [25:0] q;
    logic [24:0] bearing_next;

    assign same   = f1_sign_reg.dlo_zero && f1_sign_reg.dla_zero;
    assign lo_neg = f1_sign_reg.dlo_neg;
    assign lo_pos = !f1_sign_reg.dlo_neg && !f1_sign_reg.dlo_zero;
    assign la_neg = f1_sign_reg.dla_neg;
    assign la_pos = !f1_sign_reg.dla_neg && !f1_sign_reg.dla_zero;

    always_comb
    begin
        if (lo_pos && !la_pos)
            b = DEG180 - 33'(f1_a_reg);
        else if (!lo_pos && la_neg)
            b = 33'(f1_a_reg) + DEG180;
        else if (lo_neg && !la_neg)
            b = DEG360 - 33'(f1_a_reg);
        else
            b = 33'(f1_a_reg);
    end

    assign rnd = 34'(b) + 34'd128;
    assign q   = rnd[33:8];
    assign bearing_next = (same || q >= FULL_TURN) ? '0 : q[24:0];

    // ---------------- output register and skid entry
    logic        out_valid_reg;
    logic [24:0] out_bearing_reg;
    logic        out_same_reg;
    logic        skid_valid_reg;
    logic [24:0] skid_bearing_reg;
    logic        skid_same_reg;
    logic        pop;

    assign en  = !skid_valid_reg;
    assign pop = out_valid_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (f1_valid_reg)
        begin
            if (!out_valid_reg || pop)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_bearing_reg <= skid_bearing_reg;
                out_same_reg    <= skid_same_reg;
            end
        end
        else if (f1_valid_reg)
        begin
            if (!out_valid_reg || pop)
            begin
                out_bearing_reg <= bearing_next;
                out_same_reg    <= same;
            end
            else
            begin
                skid_bearing_reg <= bearing_next;
                skid_same_reg    <= same;
            end
        end
    end

    assign s_tready = en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_bearing_reg};
    assign m_tuser  = out_same_reg;

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without an output transaction");

    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !m_tready) |=> skid_valid_reg)
        else $error("skid entry dropped while output stalled");

    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        (f1_valid_reg && out_valid_reg && !m_tready && !skid_valid_reg) |=> skid_valid_reg)
        else $error("finished result not captured while output stalled");

    a_same_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("coincident points with nonzero bearing");
`endif

endmodule

`default_nettype wire

### verif/tb_bearing_between_coordinates_unit.sv
// Self-checking testbench for the bearing unit: directed table, then random coordinate pairs.
`default_nettype none

module tb_bearing_between_coordinates_unit;

    localparam int STEPS     = 20;
    localparam int LATENCY   = 2 * STEPS + 4;
    localparam int N_RANDOM  = 1100;
    localparam longint CYCLE_LIMIT = 400000;

    localparam longint LON_MAX = 754974720;
    localparam longint LAT_MAX = 377487360;

    localparam longint A_DEG90  = 64'sd1509949440;
    localparam longint A_DEG180 = 64'sd3019898880;
    localparam longint A_DEG360 = 64'sd6039797760;

    typedef struct packed {
        logic [24:0] bearing;
        logic        same_point;
    } bearing_t;

    typedef struct {
        longint from_lon;
        longint from_lat;
        longint to_lon;
        longint to_lat;
        bit     known;      // expected result typed in below
        int     bearing;
        bit     same_point;
    } coord_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;
    logic         m_tuser;

    bearing_t bearing_q[$];
    int       fail_count;
    longint   cycle_count = 0;
    int       send_idle_pct;
    int       recv_idle_pct;

    bearing_between_coordinates_unit #(.CORDIC_STEPS(STEPS)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint atan_deg24(int i);
        longint head[11];
        head = '{754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
                 15018523, 7509720, 3754917, 1877466, 938734};
        if (i <= 10)
            return head[i];
        return (longint'(961263669) + (longint'(1) << (i - 1))) >>> i;
    endfunction

    // cos in Q30 of an angle in degrees * 2^24 (0 .. 90)
    function automatic longint cos_q30(longint theta);
        longint x, y, z, dx, dy;
        x = 652032874;
        y = 0;
        z = theta;
        for (int i = 0; i < STEPS; i++)
        begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= atan_deg24(i);
            end
            else
            begin
                x += dx; y -= dy; z += atan_deg24(i);
            end
        end
        if (x < 0) x = 0;
        if (x > (longint'(1) << 30)) x = longint'(1) << 30;
        return x;
    endfunction

    function automatic longint atan_east_north(longint north, longint east);
        longint x, y, z, dx, dy;
        x = north;
        y = east;
        z = 0;
        for (int i = 0; i < STEPS; i++)
        begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (y > 0)
            begin
                x += dx; y -= dy; z += atan_deg24(i);
            end
            else
            begin
                x -= dx; y += dy; z -= atan_deg24(i);
            end
        end
        if (z < 0) z = 0;
        if (z > A_DEG90) z = A_DEG90;
        return z;
    endfunction

    function automatic bearing_t predict_bearing(longint flon, longint flat,
                                                 longint tlon, longint tlat);
        bearing_t r;
        longint dlo, dla, lat_abs, c, a, b, q;
        longint unsigned ulo, ula, east, north;
        dlo = tlon - flon;
        dla = tlat - flat;
        r = '0;
        if (dlo == 0 && dla == 0)
        begin
            r.same_point = 1'b1;
            return r;
        end
        lat_abs = flat < 0 ? -flat : flat;
        if (lat_abs > (A_DEG90 >>> 2))
            lat_abs = (A_DEG180 >>> 2) - lat_abs;
        c = cos_q30(lat_abs * 4);
        if (dla == 0)
            a = A_DEG90;
        else
        begin
            ulo = dlo < 0 ? -dlo : dlo;
            ula = dla < 0 ? -dla : dla;
            east = (ulo * longint'(c)) >> 8;
            north = ula << 22;
            a = atan_east_north(north, east);
        end
        if (dlo > 0 && dla <= 0)
            b = A_DEG180 - a;
        else if (dlo <= 0 && dla < 0)
            b = a + A_DEG180;
        else if (dlo < 0 && dla >= 0)
            b = A_DEG360 - a;
        else
            b = a;
        q = (b + 128) >>> 8;
        if (q >= 23592960)
            q = 0;
        r.bearing = q[24:0];
        return r;
    endfunction

    task automatic send_pair(longint flon, longint flat, longint tlon, longint tlat,
                             bit known, int exp_bearing, bit exp_same);
        bearing_t r;
        while (($urandom % 100) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        r = predict_bearing(flon, flat, tlon, tlat);
        if (known && (r.bearing != exp_bearing[24:0] || r.same_point != exp_same))
        begin
            $error("predictor disagrees with table: bearing exp %0d got %0d",
                   exp_bearing, r.bearing);
            fail_count++;
        end
        if (known)
        begin
            r.bearing = exp_bearing[24:0];
            r.same_point = exp_same;
        end
        s_tdata  <= {6'd0, tlat[29:0], tlon[30:0], flat[29:0], flon[30:0]};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bearing_q.push_back(r);
        @(negedge clk);
    endtask

    function automatic longint rand_range(longint lo, longint hi);
        return lo + longint'({$urandom, $urandom} % longint'(hi - lo + 1));
    endfunction

    task automatic send_random();
        longint flon, flat, tlon, tlat;
        int mode;
        mode = $urandom_range(0, 9);
        flon = rand_range(-LON_MAX, LON_MAX);
        flat = rand_range(-LAT_MAX, LAT_MAX);
        case (mode)
            0: begin tlon = flon; tlat = flat; end
            1: begin tlon = rand_range(-LON_MAX, LON_MAX); tlat = flat; end
            2: begin tlon = flon; tlat = rand_range(-LAT_MAX, LAT_MAX); end
            3:
            begin
                // nearby target, small differences
                tlon = flon + $signed($urandom_range(0, 2000)) - 1000;
                tlat = flat + $signed($urandom_range(0, 2000)) - 1000;
            end
            4:
            begin
                // raw bit patterns to cover every bit, out of range too
                flon = $urandom;
                flon = {{33{flon[30]}}, flon[30:0]};
                flat = $urandom;
                flat = {{34{flat[29]}}, flat[29:0]};
                tlon = $urandom;
                tlon = {{33{tlon[30]}}, tlon[30:0]};
                tlat = $urandom;
                tlat = {{34{tlat[29]}}, tlat[29:0]};
            end
            default:
            begin
                tlon = rand_range(-LON_MAX, LON_MAX);
                tlat = rand_range(-LAT_MAX, LAT_MAX);
            end
        endcase
        send_pair(flon, flat, tlon, tlat, 1'b0, 0, 1'b0);
    endtask

    // receiver stalls
    always @(negedge clk)
    begin
        m_tready <= rst_n && (($urandom % 100) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        bearing_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.bearing = m_tdata[24:0];
            got.same_point = m_tuser;
            if (bearing_q.size() == 0)
            begin
                $error("unexpected result: bearing %0d same_point %0b",
                       got.bearing, got.same_point);
                fail_count++;
            end
            else
            begin
                want = bearing_q.pop_front();
                if (got.bearing !== want.bearing)
                begin
                    $error("bearing mismatch: expected %0d actual %0d",
                           want.bearing, got.bearing);
                    fail_count++;
                end
                if (got.same_point !== want.same_point)
                begin
                    $error("same_point mismatch: expected %0b actual %0b",
                           want.same_point, got.same_point);
                    fail_count++;
                end
                if (m_tdata[31:25] !== 7'd0)
                begin
                    $error("m_tdata pad mismatch: expected 0 actual %0h", m_tdata[31:25]);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        coord_row_t rows[$];
        int         fin_wait;
        fail_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // same point, then each axis and quadrant, extremes
        rows.push_back('{0, 0, 0, 0, 1, 0, 1});
        rows.push_back('{LON_MAX, LAT_MAX, LON_MAX, LAT_MAX, 1, 0, 1});
        rows.push_back('{0, 0, 0, 4194304, 0, 0, 0});            // due north
        rows.push_back('{0, 0, 4194304, 0, 1, 5898240, 0});      // due east
        rows.push_back('{0, 0, 0, -4194304, 0, 0, 0});           // due south
        rows.push_back('{0, 0, -4194304, 0, 1, 17694720, 0});    // due west
        rows.push_back('{0, 0, 4194304, 4194304, 0, 0, 0});
        rows.push_back('{0, 0, 4194304, -4194304, 0, 0, 0});
        rows.push_back('{0, 0, -4194304, -4194304, 0, 0, 0});
        rows.push_back('{0, 0, -4194304, 4194304, 0, 0, 0});
        rows.push_back('{0, 0, -1, LAT_MAX, 0, 0, 0});           // near full circle
        rows.push_back('{-LON_MAX, -LAT_MAX, LON_MAX, LAT_MAX, 0, 0, 0});
        rows.push_back('{LON_MAX, LAT_MAX, -LON_MAX, -LAT_MAX, 0, 0, 0});
        rows.push_back('{0, LAT_MAX, LON_MAX, LAT_MAX - 1, 0, 0, 0});   // pole start
        rows.push_back('{0, -LAT_MAX, 5, -LAT_MAX + 3, 0, 0, 0});
        rows.push_back('{0, 536870911, 7, 0, 0, 0, 0});          // lat beyond 90
        rows.push_back('{-1073741824, -536870912, 1073741823, 536870911, 0, 0, 0});
        rows.push_back('{1, 1, 0, 0, 0, 0, 0});
        rows.push_back('{LON_MAX, 0, -LON_MAX, 0, 1, 17694720, 0});

        foreach (rows[i])
            send_pair(rows[i].from_lon, rows[i].from_lat, rows[i].to_lon, rows[i].to_lat,
                      rows[i].known, rows[i].bearing, rows[i].same_point);
        s_tvalid <= 1'b0;

        // hold off until the pipe drains
        while (bearing_q.size() != 0)
            @(negedge clk);

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 74 : 0;
            recv_idle_pct = (ph == 0) ? 74 : (ph == 1) ? 33 : 0;
            for (int n = 0; n < N_RANDOM / 3; n++)
                send_random();
        end
        s_tvalid <= 1'b0;

        while (bearing_q.size() != 0)
            @(negedge clk);
        fin_wait = 0;
        while (fin_wait < LATENCY * 4)
        begin
            @(negedge clk);
            fin_wait++;
        end

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
